// ===== hdl/bilinear_scale_over_blit_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear scaled over blit
// Concurrent check wrappers, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_SCALE_OVER_BLIT_TOP_DEFINES_SVH
`define BILINEAR_SCALE_OVER_BLIT_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BSO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define BSO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BSO_ASSERT_IMP(lbl, ante, cons, msg)
`define BSO_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/bso_pkg.sv =====
// ----------------------------------------------------------------------------
// bso_pkg
// Shared types and constants of the bilinear scaled over blit.
// ----------------------------------------------------------------------------
package bso_pkg;

  localparam int TEX_MAX_W_DEF = 512;
  localparam int TEX_MAX_H_DEF = 128;
  localparam int FRAME_W_DEF   = 2048;
  localparam int FRAME_H_DEF   = 2048;

  // widest texel index over the whole parameter range (4096 texels)
  localparam int IDX_W = 12;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_BLEND = 1'b1;

  localparam logic [2:0] REG_DEST_LEFT   = 3'd0;
  localparam logic [2:0] REG_DEST_TOP    = 3'd1;
  localparam logic [2:0] REG_DEST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DEST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_SRC_WIDTH   = 3'd4;
  localparam logic [2:0] REG_SRC_HEIGHT  = 3'd5;
  localparam logic [2:0] REG_OPACITY     = 3'd6;

  // 255 * 2^24, full coverage at the sample scale
  localparam logic [31:0] ONE_SCALED = 32'hFF00_0000;
  // 255 * 256: this or any larger scaled sum saturates
  localparam logic [16:0] SAT_LIMIT  = 17'd65280;

  typedef struct packed {
    logic       action;
    logic [8:0] texel_col;
    logic [6:0] texel_row;
    logic [10:0] pixel_col;
    logic [10:0] pixel_row;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [10:0] out_col;
    logic [10:0] out_row;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        covered;
  } out_item_t;

  typedef struct packed {
    logic signed [16:0] dest_left;
    logic signed [16:0] dest_top;
    logic [15:0] dest_width;
    logic [15:0] dest_height;
    logic [9:0]  source_width;
    logic [7:0]  source_height;
    logic [8:0]  opacity;
  } cfg_t;

  typedef struct packed {
    in_item_t         item;
    logic             covered;
    logic [IDX_W-1:0] x0;
    logic [IDX_W-1:0] x1;
    logic [IDX_W-1:0] y0;
    logic [IDX_W-1:0] y1;
    logic [7:0]       ax;
    logic [7:0]       ay;
  } mid_t;

endpackage

// ===== hdl/bso_div.sv =====
// ----------------------------------------------------------------------------
// bso_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bso_div #(
  parameter int NW = 42
) (
  input  logic             clk,
  input  logic [NW-1:0]    dividend,
  input  logic [15:0]      divisor,
  output logic [NW-17:0]   quotient
);

  localparam int QW = NW - 16;

  logic [NW-1:0] rem_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [15:0]   dvs_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [15:0]   dvs_in;
    logic [NW-1:0] shd;
    if (s == 0) begin : g_first
      assign rem_in = dividend;
      assign quo_in = '0;
      assign dvs_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign dvs_in = dvs_r[s-1];
    end
    assign shd = NW'(dvs_in) << (QW - 1 - s);
    always_ff @(posedge clk) begin
      if (rem_in >= shd) begin
        rem_r[s] <= rem_in - shd;
        quo_r[s] <= {quo_in[QW-2:0], 1'b1};
      end else begin
        rem_r[s] <= rem_in;
        quo_r[s] <= {quo_in[QW-2:0], 1'b0};
      end
      dvs_r[s] <= dvs_in;
    end
  end

  assign quotient = quo_r[QW-1];

endmodule

// ===== hdl/bso_front.sv =====
// ----------------------------------------------------------------------------
// bso_front
// Maps pixel centres into the rectangle, checks coverage, finds texel indices.
// ----------------------------------------------------------------------------
module bso_front #(
  parameter int TEX_MAX_W = bso_pkg::TEX_MAX_W_DEF,
  parameter int TEX_MAX_H = bso_pkg::TEX_MAX_H_DEF,
  parameter int FRAME_W   = bso_pkg::FRAME_W_DEF,
  parameter int FRAME_H   = bso_pkg::FRAME_H_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bso_pkg::cfg_t    cfg,
  input  logic             in_valid,
  input  bso_pkg::in_item_t in_item,
  output logic             mid_valid,
  output bso_pkg::mid_t    mid_item
);

  localparam int TWX = $clog2(TEX_MAX_W + 1);
  localparam int TWY = $clog2(TEX_MAX_H + 1);
  localparam int TW  = (TWX > TWY) ? TWX : TWY;
  localparam int QW  = TW + 8;
  localparam int NW  = 16 + QW;

  // locate result: {i0, i1, weight}
  function automatic logic [2*TW+7:0] locate(input logic [QW-1:0] q,
                                            input logic [TW-1:0] tex);
    logic [QW-1:0] fm;
    logic [TW-1:0] i0;
    logic [TW-1:0] i1;
    logic [7:0]    wt;
    i0 = '0;
    wt = '0;
    fm = q - QW'(128);
    if (q >= QW'(128)) begin
      i0 = TW'(fm >> 8);
      wt = fm[7:0];
    end
    if (i0 > tex - TW'(1)) i0 = tex - TW'(1);
    if ((32'(i0) + 32'd1) < 32'(tex)) i1 = i0 + TW'(1);
    else i1 = tex - TW'(1);
    return {i0, i1, wt};
  endfunction

  // stage A: centre offsets
  logic                 va_r;
  bso_pkg::in_item_t    ia_r;
  logic signed [17:0]   oxa_r, oya_r;
  logic                 fra_r;

  // stage B: coverage and dividends
  logic                 vb_r;
  bso_pkg::in_item_t    ib_r;
  logic                 cvb_r;
  logic [NW-1:0]        nx_r, ny_r;

  logic [TW-1:0] sw_s, sh_s;
  logic          cov_nxt;
  logic [QW-1:0] qx, qy;

  // side line alongside the dividers
  logic              sv_r [QW];
  bso_pkg::in_item_t si_r [QW];
  logic              sc_r [QW];

  logic          vc_r;
  bso_pkg::mid_t mc_r;
  bso_pkg::mid_t mc_nxt;
  logic [2*TW+7:0] lx, ly;

  always_comb begin
    if (cfg.source_width == '0) sw_s = TW'(1);
    else if (32'(cfg.source_width) > TEX_MAX_W) sw_s = TW'(TEX_MAX_W);
    else sw_s = TW'(cfg.source_width);
    if (cfg.source_height == '0) sh_s = TW'(1);
    else if (32'(cfg.source_height) > TEX_MAX_H) sh_s = TW'(TEX_MAX_H);
    else sh_s = TW'(cfg.source_height);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
    ia_r  <= in_item;
    oxa_r <= $signed({3'b000, in_item.pixel_col, 4'b1000}) - 18'(cfg.dest_left);
    oya_r <= $signed({3'b000, in_item.pixel_row, 4'b1000}) - 18'(cfg.dest_top);
    fra_r <= (32'(in_item.pixel_col) < FRAME_W) && (32'(in_item.pixel_row) < FRAME_H);
  end

  assign cov_nxt = fra_r && (cfg.dest_width != '0) && (cfg.dest_height != '0) &&
                   !oxa_r[17] && (oxa_r[16:0] < 17'(cfg.dest_width)) &&
                   !oya_r[17] && (oya_r[16:0] < 17'(cfg.dest_height));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    ib_r  <= ia_r;
    cvb_r <= cov_nxt;
    nx_r  <= (NW'(oxa_r[15:0]) * NW'(sw_s)) << 8;
    ny_r  <= (NW'(oya_r[15:0]) * NW'(sh_s)) << 8;
  end

  bso_div #(.NW(NW)) u_div_x (
    .clk      (clk),
    .dividend (nx_r),
    .divisor  (cfg.dest_width),
    .quotient (qx)
  );

  bso_div #(.NW(NW)) u_div_y (
    .clk      (clk),
    .dividend (ny_r),
    .divisor  (cfg.dest_height),
    .quotient (qy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) sv_r[i] <= 1'b0;
    end else begin
      sv_r[0] <= vb_r;
      for (int i = 1; i < QW; i++) sv_r[i] <= sv_r[i-1];
    end
    si_r[0] <= ib_r;
    sc_r[0] <= cvb_r;
    for (int i = 1; i < QW; i++) begin
      si_r[i] <= si_r[i-1];
      sc_r[i] <= sc_r[i-1];
    end
  end

  always_comb begin
    lx = locate(qx, sw_s);
    ly = locate(qy, sh_s);
    mc_nxt.item    = si_r[QW-1];
    mc_nxt.covered = sc_r[QW-1];
    mc_nxt.x0      = bso_pkg::IDX_W'(lx[2*TW+7:TW+8]);
    mc_nxt.x1      = bso_pkg::IDX_W'(lx[TW+7:8]);
    mc_nxt.ax      = lx[7:0];
    mc_nxt.y0      = bso_pkg::IDX_W'(ly[2*TW+7:TW+8]);
    mc_nxt.y1      = bso_pkg::IDX_W'(ly[TW+7:8]);
    mc_nxt.ay      = ly[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= sv_r[QW-1];
    end
    mc_r <= mc_nxt;
  end

  assign mid_valid = vc_r;
  assign mid_item  = mc_r;

endmodule

// ===== hdl/bso_fifo.sv =====
// ----------------------------------------------------------------------------
// bso_fifo
// Small synchronous queue, head shown combinationally.
// ----------------------------------------------------------------------------
module bso_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + AW'(1);
      if (rd_en) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  assign rd_data = mem[rp_r];
  assign empty   = (cnt_r == '0);

endmodule

// ===== hdl/bso_back.sv =====
// ----------------------------------------------------------------------------
// bso_back
// Banked texture store, bilinear filter, opacity and over blend, result queue.
// ----------------------------------------------------------------------------
module bso_back #(
  parameter int TEX_MAX_W = bso_pkg::TEX_MAX_W_DEF,
  parameter int TEX_MAX_H = bso_pkg::TEX_MAX_H_DEF,
  parameter int OQ        = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bso_pkg::cfg_t      cfg,
  input  logic               mid_empty,
  input  bso_pkg::mid_t      mid_item,
  output logic               mid_pop,
  input  logic               out_take,
  output logic               out_empty,
  output bso_pkg::out_item_t out_item
);

  localparam int HW  = (TEX_MAX_W + 1) / 2;
  localparam int HH  = (TEX_MAX_H + 1) / 2;
  localparam int BD  = HW * HH;
  localparam int AW  = (BD > 1) ? $clog2(BD) : 1;
  localparam int OCW = $clog2(OQ + 1);

  function automatic logic [AW-1:0] baddr(input logic [bso_pkg::IDX_W-1:0] c,
                                          input logic [bso_pkg::IDX_W-1:0] r);
    return AW'(((32'(r) >> 1) * HW) + (32'(c) >> 1));
  endfunction

  logic [OCW-1:0] occ_r;
  logic           load_exit;
  logic           fifo_wr;

  // stage 1: addresses
  logic          v1_r;
  bso_pkg::mid_t m1_r;
  logic [AW-1:0] ra1_r [4];
  logic [AW-1:0] wa1_r;
  logic [1:0]    wb1_r;
  logic          we1_r;
  logic [AW-1:0] ra_nxt [4];

  // stage 2: bank reads
  logic          v2_r;
  bso_pkg::mid_t m2_r;
  logic [31:0]   rd_r [4];

  // stage 3..7
  logic          v3_r, v4_r, v5_r, v6_r, v7_r;
  bso_pkg::mid_t m3_r, m4_r, m5_r, m6_r;
  logic [16:0]   top_r [4];
  logic [16:0]   bot_r [4];
  logic [23:0]   vs_r  [4];
  logic [31:0]   sp_r  [4];
  logic [16:0]   t_r   [3];
  logic          act7_r;
  bso_pkg::out_item_t o7_r;

  logic [31:0] t00, t10, t01, t11;
  logic [8:0]  op_s;

  assign mid_pop = !mid_empty && (occ_r < OCW'(OQ));

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      ra_nxt[b] = baddr((mid_item.x0[0] == b[0]) ? mid_item.x0 : mid_item.x1,
                        (mid_item.y0[0] == b[1]) ? mid_item.y0 : mid_item.y1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= mid_pop;
    end
    m1_r <= mid_item;
    for (int b = 0; b < 4; b++) ra1_r[b] <= ra_nxt[b];
    wa1_r <= baddr(bso_pkg::IDX_W'(mid_item.item.texel_col),
                   bso_pkg::IDX_W'(mid_item.item.texel_row));
    wb1_r <= {mid_item.item.texel_row[0], mid_item.item.texel_col[0]};
    we1_r <= (mid_item.item.action == bso_pkg::ACT_LOAD) &&
             (32'(mid_item.item.texel_col) < TEX_MAX_W) &&
             (32'(mid_item.item.texel_row) < TEX_MAX_H);
  end

  // four banks by row and column parity, so a 2x2 footprint is one read each
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [31:0] mem [BD];
    always_ff @(posedge clk) begin
      if (v1_r && we1_r && (wb1_r == 2'(b))) begin
        mem[wa1_r] <= {m1_r.item.alpha_in, m1_r.item.blue_in,
                       m1_r.item.green_in, m1_r.item.red_in};
      end
      rd_r[b] <= mem[ra1_r[b]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    m2_r <= m1_r;
  end

  assign t00 = rd_r[{m2_r.y0[0], m2_r.x0[0]}];
  assign t10 = rd_r[{m2_r.y0[0], m2_r.x1[0]}];
  assign t01 = rd_r[{m2_r.y1[0], m2_r.x0[0]}];
  assign t11 = rd_r[{m2_r.y1[0], m2_r.x1[0]}];

  // horizontal lerp
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      top_r[k] <= 17'(t00[8*k +: 8]) * 17'(9'd256 - 9'(m2_r.ax)) +
                  17'(t10[8*k +: 8]) * 17'(m2_r.ax);
      bot_r[k] <= 17'(t01[8*k +: 8]) * 17'(9'd256 - 9'(m2_r.ax)) +
                  17'(t11[8*k +: 8]) * 17'(m2_r.ax);
    end
    m3_r <= m2_r;
  end

  // vertical lerp
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      vs_r[k] <= 24'(top_r[k]) * 24'(9'd256 - 9'(m3_r.ay)) +
                 24'(bot_r[k]) * 24'(m3_r.ay);
    end
    m4_r <= m3_r;
  end

  assign op_s = (cfg.opacity > 9'd256) ? 9'd256 : cfg.opacity;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) sp_r[k] <= 32'(vs_r[k]) * 32'(op_s);
    m5_r <= m4_r;
  end

  // over: (S*255 + d*(ONE - Sa)) >> 24, the /255 follows
  always_ff @(posedge clk) begin
    logic [40:0] num;
    logic [7:0]  d;
    for (int k = 0; k < 3; k++) begin
      d = (k == 0) ? m5_r.item.red_in : ((k == 1) ? m5_r.item.green_in :
                                          m5_r.item.blue_in);
      num = (41'(sp_r[k]) << 8) - 41'(sp_r[k]) +
            41'(d) * 41'(bso_pkg::ONE_SCALED - sp_r[3]);
      t_r[k] <= num[40:24];
    end
    m6_r <= m5_r;
  end

  function automatic logic [7:0] div255(input logic [16:0] t);
    logic [16:0] s;
    s = t + 17'd1 + (t >> 8);
    if (t >= bso_pkg::SAT_LIMIT) return 8'd255;
    return s[15:8];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
    act7_r         <= m6_r.item.action;
    o7_r.out_col   <= m6_r.item.pixel_col;
    o7_r.out_row   <= m6_r.item.pixel_row;
    o7_r.covered   <= m6_r.covered;
    o7_r.red_out   <= m6_r.covered ? div255(t_r[0]) : m6_r.item.red_in;
    o7_r.green_out <= m6_r.covered ? div255(t_r[1]) : m6_r.item.green_in;
    o7_r.blue_out  <= m6_r.covered ? div255(t_r[2]) : m6_r.item.blue_in;
  end

  assign fifo_wr   = v7_r && (act7_r == bso_pkg::ACT_BLEND);
  assign load_exit = v7_r && (act7_r == bso_pkg::ACT_LOAD);

  // words in the back pipe plus words waiting in the result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + OCW'(mid_pop) - OCW'(out_take) - OCW'(load_exit);
    end
  end

  bso_fifo #(.WIDTH($bits(bso_pkg::out_item_t)), .DEPTH(OQ)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fifo_wr),
    .wr_data (o7_r),
    .rd_en   (out_take),
    .rd_data (out_item),
    .empty   (out_empty)
  );

endmodule

// ===== hdl/bilinear_scale_over_blit_top.sv =====
// ----------------------------------------------------------------------------
// bilinear_scale_over_blit_top - bilinear scaled premultiplied over blit
// Throughput: one word per cycle while full is low; the two pipelined dividers take a word a cycle.
// Reset clears queues, pipe valids and config registers; texture store is undefined.
// ----------------------------------------------------------------------------
`include "bilinear_scale_over_blit_top_defines.svh"

module bilinear_scale_over_blit_top #(
  parameter int TEX_MAX_W = bso_pkg::TEX_MAX_W_DEF,
  parameter int TEX_MAX_H = bso_pkg::TEX_MAX_H_DEF,
  parameter int FRAME_W   = bso_pkg::FRAME_W_DEF,
  parameter int FRAME_H   = bso_pkg::FRAME_H_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input word queue
  input  logic               push,
  output logic               full,
  input  bso_pkg::in_item_t  in_data,
  // result queue
  input  logic               pop,
  output logic               empty,
  output bso_pkg::out_item_t out_data,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Front: offset, coverage, two dividers (QW stages), texel locate.
  // Mid queue holds every word in the front pipe or waiting for the back,
  // so the front never has to stall. Back: banked store, filter, blend.
  localparam int TWX = $clog2(TEX_MAX_W + 1);
  localparam int TWY = $clog2(TEX_MAX_H + 1);
  localparam int TW  = (TWX > TWY) ? TWX : TWY;
  localparam int QW  = TW + 8;
  localparam int MQ  = 2 ** $clog2(QW + 8);
  localparam int MCW = $clog2(MQ + 1);
  localparam int OQ  = 16;

  bso_pkg::cfg_t cfg_r;
  logic [2:0]    reg_idx;
  logic          cfg_wr;

  logic          in_take;
  logic          out_take;
  logic [MCW-1:0] occ_m_r;

  logic          mid_valid;
  bso_pkg::mid_t mid_wr_item;
  bso_pkg::mid_t mid_rd_item;
  logic          mid_empty;
  logic          mid_pop;

  // ---- register port ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_left     <= '0;
      cfg_r.dest_top      <= '0;
      cfg_r.dest_width    <= 16'd16;
      cfg_r.dest_height   <= 16'd16;
      cfg_r.source_width  <= 10'd1;
      cfg_r.source_height <= 8'd1;
      cfg_r.opacity       <= 9'd256;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bso_pkg::REG_DEST_LEFT:   cfg_r.dest_left     <= $signed(pwdata[16:0]);
        bso_pkg::REG_DEST_TOP:    cfg_r.dest_top      <= $signed(pwdata[16:0]);
        bso_pkg::REG_DEST_WIDTH:  cfg_r.dest_width    <= pwdata[15:0];
        bso_pkg::REG_DEST_HEIGHT: cfg_r.dest_height   <= pwdata[15:0];
        bso_pkg::REG_SRC_WIDTH:   cfg_r.source_width  <= pwdata[9:0];
        bso_pkg::REG_SRC_HEIGHT:  cfg_r.source_height <= pwdata[7:0];
        bso_pkg::REG_OPACITY:     cfg_r.opacity       <= pwdata[8:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bso_pkg::REG_DEST_LEFT:   prdata = {15'd0, cfg_r.dest_left};
      bso_pkg::REG_DEST_TOP:    prdata = {15'd0, cfg_r.dest_top};
      bso_pkg::REG_DEST_WIDTH:  prdata = {16'd0, cfg_r.dest_width};
      bso_pkg::REG_DEST_HEIGHT: prdata = {16'd0, cfg_r.dest_height};
      bso_pkg::REG_SRC_WIDTH:   prdata = {22'd0, cfg_r.source_width};
      bso_pkg::REG_SRC_HEIGHT:  prdata = {24'd0, cfg_r.source_height};
      bso_pkg::REG_OPACITY:     prdata = {23'd0, cfg_r.opacity};
      default:                  prdata = '0;
    endcase
  end

  // ---- input side credit: front pipe + mid queue never exceed MQ ----
  assign in_take = push && !full;
  assign full    = (occ_m_r == MCW'(MQ));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_m_r <= '0;
    end else begin
      occ_m_r <= occ_m_r + MCW'(in_take) - MCW'(mid_pop);
    end
  end

  bso_front #(
    .TEX_MAX_W (TEX_MAX_W),
    .TEX_MAX_H (TEX_MAX_H),
    .FRAME_W   (FRAME_W),
    .FRAME_H   (FRAME_H)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_take),
    .in_item   (in_data),
    .mid_valid (mid_valid),
    .mid_item  (mid_wr_item)
  );

  bso_fifo #(.WIDTH($bits(bso_pkg::mid_t)), .DEPTH(MQ)) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_valid),
    .wr_data (mid_wr_item),
    .rd_en   (mid_pop),
    .rd_data (mid_rd_item),
    .empty   (mid_empty)
  );

  assign out_take = pop && !empty;

  bso_back #(
    .TEX_MAX_W (TEX_MAX_W),
    .TEX_MAX_H (TEX_MAX_H),
    .OQ        (OQ)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_empty (mid_empty),
    .mid_item  (mid_rd_item),
    .mid_pop   (mid_pop),
    .out_take  (out_take),
    .out_empty (empty),
    .out_item  (out_data)
  );

  // ---- checks ----
  `BSO_ASSERT_IMP(a_mid_bound, 1'b1, occ_m_r <= MCW'(MQ), "mid credit overrun")
  `BSO_ASSERT_IMP(a_reset_idle, $past(rst_n) == 1'b0, empty && !full, "not idle after reset")
  `BSO_ASSERT_NXT(a_opacity_wr, cfg_wr && (reg_idx == bso_pkg::REG_OPACITY), cfg_r.opacity == $past(pwdata[8:0]), "opacity write lost")

endmodule
